// ----- hdl/rpl_pkg.sv -----
// ----------------------------------------------------------------------------
// rpl_pkg
// Shared types and constants of the /24 route lookup cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rpl_pkg;

    localparam int RPL_DEPTH      = 256;
    localparam int RPL_KEY_W      = 24;
    localparam int RPL_PORT_W     = 16;
    localparam int RPL_IN_DATA_W  = 40;
    localparam int RPL_OUT_USER_W = 2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // item travelling down the chain, one cell per cycle while the chain advances
    typedef struct packed {
        logic                  vld;
        logic                  lookup;
        logic [RPL_KEY_W-1:0]  key;
        logic [RPL_PORT_W-1:0] port;   // load: port to store; lookup: default, then hit port
        logic                  hit;    // load: placed; lookup: matched an entry
        logic                  dflt;   // lookup: default route present at entry
    } t_token;

endpackage

`default_nettype wire

// ----- hdl/route_prefix_lookup_default_unit.sv -----
// ----------------------------------------------------------------------------
// route_prefix_lookup_default_unit
// Exact-match /24 route table with a separate default route.
// ----------------------------------------------------------------------------
// Items flow through a chain of TABLE_DEPTH cells, one cell per cycle while the
// chain advances, each cell holding one route. A load claims the first free
// cell it meets; a lookup picks up the port of the first matching cell, so the
// earliest loaded route wins. The prefix 0.0.0 sets the default route (first
// one kept) and takes no cell; a lookup samples the default as it enters. One
// item is accepted per cycle unless the chain holds, which it does while a
// result waits on the output; a lookup result leaves via the output register.
// Loads beyond TABLE_DEPTH routes fall off the end of the chain unstored.
`default_nettype none

module route_prefix_lookup_default_unit
    import rpl_pkg::*;
#(
    parameter int TABLE_DEPTH = RPL_DEPTH
)(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] octet_first, [15:8] octet_second, [23:16] octet_third,
    // [39:24] port_in
    input  wire logic [RPL_IN_DATA_W-1:0]    s_axis_tdata,
    // [0] mode
    input  wire logic                        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [15:0] port_out
    output logic [RPL_PORT_W-1:0]            m_axis_tdata,
    // [0] route_found, [1] used_default
    output logic [RPL_OUT_USER_W-1:0]        m_axis_tuser
);

    t_token                  w_tok [TABLE_DEPTH+1];
    t_token                  w_head;
    logic [TABLE_DEPTH-1:0]  w_used;
    logic                    w_adv;
    logic                    w_accept;
    logic [RPL_KEY_W-1:0]    w_key;
    logic                    w_is_dflt;
    logic                    r_dflt_valid;
    logic                    n_dflt_valid;
    logic [RPL_PORT_W-1:0]   r_dflt_port;
    logic [RPL_PORT_W-1:0]   n_dflt_port;

    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;
    assign w_key         = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    assign w_is_dflt     = (w_key == '0);
    assign w_tok[0]      = w_head;

    always_comb begin
        w_head.vld    = w_accept && ((s_axis_tuser == MODE_LOOKUP) || !w_is_dflt);
        w_head.lookup = (s_axis_tuser == MODE_LOOKUP);
        w_head.key    = w_key;
        w_head.port   = (s_axis_tuser == MODE_LOOKUP) ? r_dflt_port
                                                      : s_axis_tdata[39:24];
        w_head.hit    = 1'b0;
        w_head.dflt   = r_dflt_valid;

        n_dflt_valid = r_dflt_valid;
        n_dflt_port  = r_dflt_port;
        if (w_accept && (s_axis_tuser == MODE_LOAD) && w_is_dflt && !r_dflt_valid) begin
            n_dflt_valid = 1'b1;
            n_dflt_port  = s_axis_tdata[39:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_valid <= 1'b0;
            r_dflt_port  <= '0;
        end else begin
            r_dflt_valid <= n_dflt_valid;
            r_dflt_port  <= n_dflt_port;
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rpl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_used  (w_used[g])
        );
    end

    rpl_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok[TABLE_DEPTH]),
        .i_ready (m_axis_tready),
        .o_adv   (w_adv),
        .o_valid (m_axis_tvalid),
        .o_port  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

`ifndef SYNTH
    logic [TABLE_DEPTH:0] w_used_inc;
    assign w_used_inc = {1'b0, w_used} + 1'b1;

    // occupied cells always form one run starting at cell 0
    a_used_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_used_inc))
        else $error("occupied cells not contiguous");

    a_default_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dflt_valid |=> r_dflt_valid && $stable(r_dflt_port))
        else $error("default route changed after being set");

    a_chain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_tok[TABLE_DEPTH]) && $stable(w_used))
        else $error("chain moved during output stall");

    a_no_route_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
        else $error("no-route result carries a port or default flag");
`endif

endmodule

`default_nettype wire

// ----- hdl/rpl_cell.sv -----
// ----------------------------------------------------------------------------
// rpl_cell
// One route entry: stores a prefix and port, matches passing lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module rpl_cell
    import rpl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire t_token i_tok,
    output t_token      o_tok,
    output logic        o_used
);

    t_token                r_tok;
    t_token                n_tok;
    logic                  r_used;
    logic                  n_used;
    logic [RPL_KEY_W-1:0]  r_prefix;
    logic [RPL_KEY_W-1:0]  n_prefix;
    logic [RPL_PORT_W-1:0] r_port;
    logic [RPL_PORT_W-1:0] n_port;

    always_comb begin
        n_tok    = i_tok;
        n_used   = r_used;
        n_prefix = r_prefix;
        n_port   = r_port;
        if (i_tok.vld && !i_tok.hit) begin
            if (i_tok.lookup) begin
                if (r_used && (r_prefix == i_tok.key)) begin
                    n_tok.hit  = 1'b1;
                    n_tok.port = r_port;
                end
            end else if (!r_used) begin
                // claim the first free cell
                n_used     = 1'b1;
                n_prefix   = i_tok.key;
                n_port     = i_tok.port;
                n_tok.hit  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_used    <= 1'b0;
        end else if (i_adv) begin
            r_tok    <= n_tok;
            r_used   <= n_used;
            r_prefix <= n_prefix;
            r_port   <= n_port;
        end
    end

    assign o_tok  = r_tok;
    assign o_used = r_used;

endmodule

`default_nettype wire

// ----- hdl/rpl_result.sv -----
// ----------------------------------------------------------------------------
// rpl_result
// Output register: turns a finished lookup into a result item.
// ----------------------------------------------------------------------------
`default_nettype none

module rpl_result
    import rpl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_token                 i_tok,
    input  wire logic                   i_ready,
    output logic                        o_adv,
    output logic                        o_valid,
    output logic [RPL_PORT_W-1:0]       o_port,
    output logic [RPL_OUT_USER_W-1:0]   o_user
);

    logic                  r_valid;
    logic                  n_valid;
    logic [RPL_PORT_W-1:0] r_port;
    logic [RPL_PORT_W-1:0] n_port;
    logic                  r_found;
    logic                  n_found;
    logic                  r_dflt;
    logic                  n_dflt;

    assign o_adv = !r_valid || i_ready;

    always_comb begin
        // loads leave the chain here and give nothing
        n_valid = i_tok.vld && i_tok.lookup;
        n_found = i_tok.hit || i_tok.dflt;
        n_dflt  = !i_tok.hit && i_tok.dflt;
        n_port  = n_found ? i_tok.port : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= n_valid;
            r_port  <= n_port;
            r_found <= n_found;
            r_dflt  <= n_dflt;
        end
    end

    assign o_valid = r_valid;
    assign o_port  = r_port;
    assign o_user  = {r_dflt, r_found};

endmodule

`default_nettype wire

// ----- verif/route_lookup_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// route_lookup_checker
// Follows the route table through every accepted load, works out the answer
// of every accepted lookup and compares the result stream against those
// answers in arrival order.
// ----------------------------------------------------------------------------
module route_lookup_checker
    import rpl_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    input  wire logic                      i_s_tready,
    // [7:0] octet_first, [15:8] octet_second, [23:16] octet_third,
    // [39:24] port_in
    input  wire logic [RPL_IN_DATA_W-1:0]  i_s_tdata,
    // [0] mode
    input  wire logic                      i_s_tuser,
    input  wire logic                      i_m_tvalid,
    input  wire logic                      i_m_tready,
    // [15:0] port_out
    input  wire logic [RPL_PORT_W-1:0]     i_m_tdata,
    // [0] route_found, [1] used_default
    input  wire logic [RPL_OUT_USER_W-1:0] i_m_tuser,
    output int                             o_errors,
    output int                             o_pending
);

    typedef struct packed {
        logic                  found;
        logic [RPL_PORT_W-1:0] port;
        logic                  via_default;
    } t_route_answer;

    logic [RPL_KEY_W-1:0]  route_key [RPL_DEPTH];
    logic [RPL_PORT_W-1:0] route_port [RPL_DEPTH];
    int                    route_count = 0;
    logic                  dflt_valid = 1'b0;
    logic [RPL_PORT_W-1:0] dflt_port = '0;
    t_route_answer         lookup_answers [$];
    int                    mismatch_count = 0;

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    function automatic t_route_answer resolve_route(logic [RPL_KEY_W-1:0] key);
        t_route_answer ans;
        ans = '{found: 1'b0, port: '0, via_default: 1'b0};
        // earliest stored match wins
        for (int n = 0; n < route_count; n++) begin
            if (route_key[n] == key) begin
                ans.found = 1'b1;
                ans.port  = route_port[n];
                return ans;
            end
        end
        if (dflt_valid) begin
            ans = '{found: 1'b1, port: dflt_port, via_default: 1'b1};
        end
        return ans;
    endfunction

    task automatic store_route(logic [RPL_KEY_W-1:0] key, logic [RPL_PORT_W-1:0] port);
        if (key == '0) begin
            // keep the first default only
            if (!dflt_valid) begin
                dflt_valid = 1'b1;
                dflt_port  = port;
            end
        end else if (route_count < RPL_DEPTH) begin
            route_key[route_count]  = key;
            route_port[route_count] = port;
            route_count++;
        end
        // drop loads once the table is full
    endtask

    always @(posedge i_clk) begin : watch
        t_route_answer        want;
        t_route_answer        got;
        logic [RPL_KEY_W-1:0] key;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = '{found: i_m_tuser[0], port: i_m_tdata, via_default: i_m_tuser[1]};
                if (lookup_answers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with no lookup pending: found %0b port %h dflt %0b",
                                 $realtime, got.found, got.port, got.via_default);
                end else begin
                    want = lookup_answers.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: lookup mismatch: exp found %0b port %h dflt %0b,",
                                      " got found %0b port %h dflt %0b"},
                                     $realtime, want.found, want.port, want.via_default,
                                     got.found, got.port, got.via_default);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                key = {i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16]};
                if (i_s_tuser == MODE_LOOKUP)
                    lookup_answers.push_back(resolve_route(key));
                else
                    store_route(key, i_s_tdata[39:24]);
            end
            o_pending <= lookup_answers.size();
            o_errors  <= mismatch_count;
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the /24 route lookup: directed route loads and lookups,
// then bursty random traffic that fills the table past capacity, with a
// stalling result receiver. Checking lives in route_lookup_checker.
// ----------------------------------------------------------------------------
module tb;
    import rpl_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = RPL_DEPTH + 64;
    localparam int RANDOM_ITEMS = 930;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [RPL_IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                      s_axis_tuser = MODE_LOAD;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [RPL_PORT_W-1:0]     m_axis_tdata;
    logic [RPL_OUT_USER_W-1:0] m_axis_tuser;
    int                        error_count;
    int                        pending_count;
    logic [RPL_KEY_W-1:0]      loaded_keys [$];
    int                        stall_mode = 0;
    int                        stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    route_prefix_lookup_default_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    route_lookup_checker u_route_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .o_errors   (error_count),
        .o_pending  (pending_count)
    );

    // receiver: always ready, lightly stalled or heavily stalled, by stretches
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_route_item(logic mode, logic [RPL_KEY_W-1:0] key,
                                   logic [RPL_PORT_W-1:0] port);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {port, key[7:0], key[15:8], key[23:16]};
        if (mode == MODE_LOAD && key != '0)
            loaded_keys.push_back(key);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic hold_off(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [RPL_KEY_W-1:0] pick_prefix(logic is_lookup);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        // small pool so duplicates and repeat hits are common
        if (r < 30)
            return {8'd10, 8'd0, 5'd0, 3'($urandom_range(0, 7))};
        if (is_lookup && loaded_keys.size() > 0 && r < 80)
            return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
        return 24'($urandom);
    endfunction

    initial begin
        int   sent;
        int   burst;
        int   r;
        logic mode;
        sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, no default
        send_route_item(MODE_LOOKUP, 24'h000000, 16'hffff);
        send_route_item(MODE_LOOKUP, 24'hffffff, 16'h0000);
        // extreme prefixes and ports
        send_route_item(MODE_LOAD,   24'hffffff, 16'hffff);
        send_route_item(MODE_LOAD,   24'h000001, 16'h0000);
        send_route_item(MODE_LOAD,   24'h800000, 16'h8000);
        send_route_item(MODE_LOOKUP, 24'hffffff, 16'h0000);
        send_route_item(MODE_LOOKUP, 24'h000001, 16'hffff);
        send_route_item(MODE_LOOKUP, 24'h800000, 16'h0000);
        send_route_item(MODE_LOOKUP, 24'h7fffff, 16'h0000);
        // duplicate prefix: first load stays
        send_route_item(MODE_LOAD,   24'hffffff, 16'h1111);
        send_route_item(MODE_LOOKUP, 24'hffffff, 16'h0000);
        // default route, then a second default that must be ignored
        send_route_item(MODE_LOAD,   24'h000000, 16'ha5a5);
        send_route_item(MODE_LOOKUP, 24'h000000, 16'h0000);
        send_route_item(MODE_LOOKUP, 24'h123456, 16'hffff);
        send_route_item(MODE_LOAD,   24'h000000, 16'h5a5a);
        send_route_item(MODE_LOOKUP, 24'h000000, 16'h0000);
        send_route_item(MODE_LOOKUP, 24'h000001, 16'h0000);
        send_route_item(MODE_LOAD,   24'h010000, 16'h0001);
        send_route_item(MODE_LOOKUP, 24'h010000, 16'h0000);
        hold_off(5);

        // random bursts; the table fills up and later loads drop
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                mode = ($urandom_range(0, 99) < 45) ? MODE_LOAD : MODE_LOOKUP;
                send_route_item(mode, pick_prefix(mode == MODE_LOOKUP), 16'($urandom));
                sent++;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                hold_off($urandom_range(100, 400));
            else if (r < 70)
                hold_off($urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("route_prefix_lookup_default_unit regression: pass");
        else
            $display("route_prefix_lookup_default_unit regression: fail");
        $finish;
    end

    // end the run when neither channel moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("route_prefix_lookup_default_unit regression: fail");
        $finish;
    end

endmodule
